// ===== design/brs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brs_pkg: shared types and constants
// Payload structs, config register map, job descriptor and FSM encodings
// for the Brusselator stencil residual block.
// ----------------------------------------------------------------------------
package brs_pkg;

  localparam int DATA_W    = 32;
  localparam int IDX_OUT_W = 12;
  localparam int CFG_IDX_W = 3;
  localparam int Q_FRAC    = 16;
  localparam int Q_ONE     = 65536;

  localparam int JOBQ_DEPTH = 4;
  localparam int OUTQ_DEPTH = 2;

  typedef struct packed {
    logic signed [DATA_W-1:0] point_u;
    logic signed [DATA_W-1:0] point_v;
    logic signed [DATA_W-1:0] rate_u;
    logic signed [DATA_W-1:0] rate_v;
    logic                     last_point;
  } item_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0]     point_index;
    logic signed [DATA_W-1:0] resid_u;
    logic signed [DATA_W-1:0] resid_v;
    logic signed [DATA_W-1:0] react_u;
    logic signed [DATA_W-1:0] react_v;
    logic                     last_result;
  } result_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_H,
    REG_DIFF_GAIN,
    REG_REACT_A,
    REG_REACT_B,
    REG_U_LEFT,
    REG_U_RIGHT,
    REG_V_LEFT,
    REG_V_RIGHT
  } cfg_reg_e;

  typedef struct packed {
    logic [16:0]              step_h;
    logic [30:0]              diff_gain;
    logic signed [DATA_W-1:0] react_a;
    logic signed [DATA_W-1:0] react_b;
    logic signed [DATA_W-1:0] u_left;
    logic signed [DATA_W-1:0] u_right;
    logic signed [DATA_W-1:0] v_left;
    logic signed [DATA_W-1:0] v_right;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    step_h:    17'd6554,
    diff_gain: 31'd13107,
    react_a:   32'sd65536,
    react_b:   32'sd196608,
    u_left:    32'sd65536,
    u_right:   32'sd65536,
    v_left:    32'sd196608,
    v_right:   32'sd196608
  };

  // Kind of work the back end performs for one result.
  typedef enum logic [1:0] {
    JOB_LEFT,
    JOB_RIGHT,
    JOB_INNER
  } job_kind_e;

  typedef struct packed {
    logic [IDX_OUT_W-1:0]     index;
    job_kind_e                kind;
    logic                     last;
    logic signed [DATA_W-1:0] center_u;
    logic signed [DATA_W-1:0] center_v;
    logic signed [DATA_W-1:0] left_u;
    logic signed [DATA_W-1:0] left_v;
    logic signed [DATA_W-1:0] right_u;
    logic signed [DATA_W-1:0] right_v;
    logic signed [DATA_W-1:0] rate_u;
    logic signed [DATA_W-1:0] rate_v;
  } job_t;

  typedef enum logic [1:0] {
    FILL_EMPTY,
    FILL_FIRST,
    FILL_FULL
  } fill_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_OUT
  } back_state_e;

endpackage

// ===== design/brs_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brs_fifo: small register FIFO
// Count-based queue used between front and back end and on the result side.
// ----------------------------------------------------------------------------
module brs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

// ===== design/brs_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brs_front: point window and job classifier
// Keeps the three-point window, numbers the points and turns each request
// into zero, one or two jobs (left boundary, interior, right boundary).
// ----------------------------------------------------------------------------
module brs_front #(
  parameter int MAX_POINTS = 4096
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  brs_pkg::item_t item,
  output logic           full,
  input  logic           job_full,
  output logic           job_push,
  output brs_pkg::job_t  job
);

  localparam int IDX_W = $clog2(MAX_POINTS);

  brs_pkg::fill_e           fill;
  logic [IDX_W-1:0]         idx;
  logic [IDX_W-1:0]         idx_inc;
  logic                     pend_valid;
  brs_pkg::job_t            pend_job;
  logic signed [31:0]       left_u, left_v;
  logic signed [31:0]       center_u, center_v;
  logic signed [31:0]       center_rate_u, center_rate_v;
  brs_pkg::job_t            job_a, job_b;
  logic                     has_a, has_b;
  logic                     accept;

  function automatic logic [brs_pkg::IDX_OUT_W-1:0] to_index(input logic [IDX_W-1:0] i);
    logic [IDX_W+brs_pkg::IDX_OUT_W-1:0] e;
    e = {{brs_pkg::IDX_OUT_W{1'b0}}, i};
    return e[brs_pkg::IDX_OUT_W-1:0];
  endfunction

  // A flush job waiting in pend_job holds off new requests.
  assign full   = pend_valid || job_full;
  assign accept = push && !full;

  always_comb begin
    job_a   = '0;
    job_b   = '0;
    has_a   = 1'b0;
    has_b   = 1'b0;
    idx_inc = (idx == IDX_W'(MAX_POINTS - 1)) ? '0 : idx + 1'b1;
    unique case (fill)
      brs_pkg::FILL_EMPTY: begin
        // single-point sweep
        has_a          = item.last_point;
        job_a.kind     = brs_pkg::JOB_LEFT;
        job_a.last     = 1'b1;
        job_a.center_u = item.point_u;
        job_a.center_v = item.point_v;
      end
      brs_pkg::FILL_FIRST: begin
        has_a          = 1'b1;
        job_a.index    = to_index(idx);
        job_a.kind     = brs_pkg::JOB_LEFT;
        job_a.center_u = center_u;
        job_a.center_v = center_v;
      end
      brs_pkg::FILL_FULL: begin
        has_a          = 1'b1;
        job_a.index    = to_index(idx);
        job_a.kind     = brs_pkg::JOB_INNER;
        job_a.center_u = center_u;
        job_a.center_v = center_v;
        job_a.left_u   = left_u;
        job_a.left_v   = left_v;
        job_a.right_u  = item.point_u;
        job_a.right_v  = item.point_v;
        job_a.rate_u   = center_rate_u;
        job_a.rate_v   = center_rate_v;
      end
      default: has_a = 1'b0;
    endcase
    if (fill != brs_pkg::FILL_EMPTY && item.last_point) begin
      has_b          = 1'b1;
      job_b.index    = to_index(idx_inc);
      job_b.kind     = brs_pkg::JOB_RIGHT;
      job_b.last     = 1'b1;
      job_b.center_u = item.point_u;
      job_b.center_v = item.point_v;
    end
  end

  assign job_push = pend_valid ? !job_full : (accept && has_a);
  assign job      = pend_valid ? pend_job : job_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill       <= brs_pkg::FILL_EMPTY;
      idx        <= '0;
      pend_valid <= 1'b0;
    end else begin
      if (pend_valid && !job_full) begin
        pend_valid <= 1'b0;
      end
      if (accept) begin
        if (has_b) begin
          pend_valid <= 1'b1;
        end
        if (item.last_point) begin
          fill <= brs_pkg::FILL_EMPTY;
          idx  <= '0;
        end else begin
          fill <= (fill == brs_pkg::FILL_EMPTY) ? brs_pkg::FILL_FIRST : brs_pkg::FILL_FULL;
          if (fill != brs_pkg::FILL_EMPTY) begin
            idx <= idx_inc;
          end
        end
      end
    end
  end

  // Window contents only matter under the fill code, so they shift freely.
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_job      <= job_b;
      left_u        <= center_u;
      left_v        <= center_v;
      center_u      <= item.point_u;
      center_v      <= item.point_v;
      center_rate_u <= item.rate_u;
      center_rate_v <= item.rate_v;
    end
  end

endmodule

// ===== design/brs_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brs_back: residual and reaction datapath
// Runs one job at a time through a shared registered 34x32 multiplier,
// sequenced by a step counter; rounds, saturates and emits the result.
// ----------------------------------------------------------------------------
module brs_back (
  input  logic             clk,
  input  logic             rst,
  input  brs_pkg::cfg_t    cfg,
  input  brs_pkg::job_t    job,
  input  logic             job_empty,
  output logic             job_pop,
  output brs_pkg::result_t res,
  input  logic             res_full,
  output logic             res_push
);

  localparam int OPA_W  = 34;
  localparam int OPB_W  = 32;
  localparam int PROD_W = OPA_W + OPB_W;
  localparam int ACC_W  = 51;
  localparam int DIFF_W = 35;
  localparam int STEP_W = 4;

  // last issue step, extended past the operand and product registers
  localparam logic [STEP_W-1:0] LAST_STEP_BND   = STEP_W'(9);
  localparam logic [STEP_W-1:0] LAST_STEP_INNER = STEP_W'(13);

  typedef enum logic [3:0] {
    OP_NONE,
    OP_UU,
    OP_B1U,
    OP_BU,
    OP_UUV,
    OP_BND_U,
    OP_BND_V,
    OP_T_U,
    OP_DL_U,
    OP_DH_U,
    OP_T_V,
    OP_DL_V,
    OP_DH_V,
    OP_RU,
    OP_RV
  } op_e;

  function automatic op_e seq_op(input logic [STEP_W-1:0] step_i, input logic inner_i);
    op_e op;
    unique case (step_i)
      STEP_W'(0):  op = OP_UU;
      STEP_W'(1):  op = OP_B1U;
      STEP_W'(2):  op = OP_BU;
      STEP_W'(3):  op = OP_UUV;
      STEP_W'(4):  op = inner_i ? OP_T_U  : OP_BND_U;
      STEP_W'(5):  op = inner_i ? OP_DL_U : OP_BND_V;
      STEP_W'(6):  op = OP_RU;
      STEP_W'(7):  op = OP_RV;
      STEP_W'(8):  op = inner_i ? OP_DH_U : OP_NONE;
      STEP_W'(9):  op = inner_i ? OP_T_V  : OP_NONE;
      STEP_W'(10): op = inner_i ? OP_DL_V : OP_NONE;
      STEP_W'(11): op = inner_i ? OP_DH_V : OP_NONE;
      default:     op = OP_NONE;
    endcase
    return op;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] x);
    logic signed [31:0] r;
    if (x > PROD_W'(64'sd2147483647)) begin
      r = 32'sh7fffffff;
    end else if (x < PROD_W'(-64'sd2147483648)) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  // round to nearest, ties up, then saturate
  function automatic logic signed [31:0] round_sat(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] r;
    r = (p + PROD_W'(32'sd32768)) >>> brs_pkg::Q_FRAC;
    return sat32(r);
  endfunction

  brs_pkg::back_state_e state, state_next;
  logic [STEP_W-1:0]    step, step_next;
  logic [STEP_W-1:0]    last_step;
  brs_pkg::job_t        job_r;
  logic                 inner;
  op_e                  cur_op, tag1, tag2;

  logic signed [OPA_W-1:0]  opa, opa_next;
  logic signed [OPB_W-1:0]  opb, opb_next;
  logic signed [PROD_W-1:0] prod;

  logic signed [31:0]       u2, b1u, bu, uuv;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_dl;
  logic signed [ACC_W:0]    acc_dh;
  logic signed [ACC_W-1:0]  prod_lo;
  logic signed [31:0]       resid_u, resid_v, react_u, react_v;

  logic signed [DIFF_W-1:0] d_u, d_v;
  logic signed [18:0]       dh_u, dh_v;
  logic [15:0]              dl_u, dl_v;
  logic signed [OPB_W-1:0]  hx_op, g_op;
  logic signed [31:0]       bnd_u, bnd_v;

  assign inner     = (job_r.kind == brs_pkg::JOB_INNER);
  assign last_step = inner ? LAST_STEP_INNER : LAST_STEP_BND;
  assign cur_op    = (state == brs_pkg::BK_RUN) ? seq_op(step, inner) : OP_NONE;

  // second difference split into a signed high part and a 16-bit low part
  assign d_u  = DIFF_W'(job_r.left_u) - (DIFF_W'(job_r.center_u) <<< 1) + DIFF_W'(job_r.right_u);
  assign d_v  = DIFF_W'(job_r.left_v) - (DIFF_W'(job_r.center_v) <<< 1) + DIFF_W'(job_r.right_v);
  assign dh_u = d_u[DIFF_W-1:16];
  assign dh_v = d_v[DIFF_W-1:16];
  assign dl_u = d_u[15:0];
  assign dl_v = d_v[15:0];

  assign hx_op = OPB_W'(signed'({1'b0, cfg.step_h}));
  assign g_op  = signed'({1'b0, cfg.diff_gain});
  assign bnd_u = (job_r.kind == brs_pkg::JOB_RIGHT) ? cfg.u_right : cfg.u_left;
  assign bnd_v = (job_r.kind == brs_pkg::JOB_RIGHT) ? cfg.v_right : cfg.v_left;

  always_comb begin
    opa_next = '0;
    opb_next = '0;
    unique case (cur_op)
      OP_UU: begin
        opa_next = OPA_W'(job_r.center_u);
        opb_next = job_r.center_u;
      end
      OP_B1U: begin
        opa_next = OPA_W'(cfg.react_b) + OPA_W'(brs_pkg::Q_ONE);
        opb_next = job_r.center_u;
      end
      OP_BU: begin
        opa_next = OPA_W'(cfg.react_b);
        opb_next = job_r.center_u;
      end
      OP_UUV: begin
        opa_next = OPA_W'(u2);
        opb_next = job_r.center_v;
      end
      OP_BND_U: begin
        opa_next = OPA_W'(job_r.center_u) - OPA_W'(bnd_u);
        opb_next = hx_op;
      end
      OP_BND_V: begin
        opa_next = OPA_W'(job_r.center_v) - OPA_W'(bnd_v);
        opb_next = hx_op;
      end
      OP_T_U: begin
        opa_next = OPA_W'(job_r.rate_u);
        opb_next = hx_op;
      end
      OP_T_V: begin
        opa_next = OPA_W'(job_r.rate_v);
        opb_next = hx_op;
      end
      OP_DL_U: begin
        opa_next = OPA_W'({1'b0, dl_u});
        opb_next = g_op;
      end
      OP_DL_V: begin
        opa_next = OPA_W'({1'b0, dl_v});
        opb_next = g_op;
      end
      OP_DH_U: begin
        opa_next = OPA_W'(dh_u);
        opb_next = g_op;
      end
      OP_DH_V: begin
        opa_next = OPA_W'(dh_v);
        opb_next = g_op;
      end
      OP_RU: begin
        opa_next = OPA_W'(cfg.react_a) + OPA_W'(uuv) - OPA_W'(b1u);
        opb_next = hx_op;
      end
      OP_RV: begin
        opa_next = OPA_W'(bu) - OPA_W'(uuv);
        opb_next = hx_op;
      end
      default: begin
        opa_next = '0;
        opb_next = '0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    job_pop    = 1'b0;
    res_push   = 1'b0;
    unique case (state)
      brs_pkg::BK_IDLE: begin
        if (!job_empty) begin
          job_pop    = 1'b1;
          step_next  = '0;
          state_next = brs_pkg::BK_RUN;
        end
      end
      brs_pkg::BK_RUN: begin
        step_next = step + 1'b1;
        if (step == last_step) begin
          state_next = brs_pkg::BK_OUT;
        end
      end
      brs_pkg::BK_OUT: begin
        if (!res_full) begin
          res_push   = 1'b1;
          state_next = brs_pkg::BK_IDLE;
        end
      end
      default: state_next = brs_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= brs_pkg::BK_IDLE;
      step  <= '0;
      tag1  <= OP_NONE;
      tag2  <= OP_NONE;
    end else begin
      state <= state_next;
      step  <= step_next;
      tag1  <= cur_op;
      tag2  <= tag1;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      job_r <= job;
    end
    opa  <= opa_next;
    opb  <= opb_next;
    prod <= PROD_W'(opa) * PROD_W'(opb);
  end

  // interior residual: floor16(t - dl*g + half) - dh*g, rounded once overall
  assign prod_lo = signed'(prod[ACC_W-1:0]);
  assign acc_dl  = (acc - prod_lo + ACC_W'(32'sd32768)) >>> brs_pkg::Q_FRAC;
  assign acc_dh  = (ACC_W+1)'(acc) - (ACC_W+1)'(prod_lo);

  always_ff @(posedge clk) begin
    unique case (tag2)
      OP_UU:    u2      <= round_sat(prod);
      OP_B1U:   b1u     <= round_sat(prod);
      OP_BU:    bu      <= round_sat(prod);
      OP_UUV:   uuv     <= round_sat(prod);
      OP_BND_U: resid_u <= round_sat(prod);
      OP_BND_V: resid_v <= round_sat(prod);
      OP_RU:    react_u <= round_sat(prod);
      OP_RV:    react_v <= round_sat(prod);
      OP_T_U,
      OP_T_V:   acc     <= prod_lo;
      OP_DL_U,
      OP_DL_V:  acc     <= acc_dl;
      OP_DH_U:  resid_u <= sat32(PROD_W'(acc_dh));
      OP_DH_V:  resid_v <= sat32(PROD_W'(acc_dh));
      default:  acc     <= acc;
    endcase
  end

  always_comb begin
    res.point_index = job_r.index;
    res.resid_u     = resid_u;
    res.resid_v     = resid_v;
    res.react_u     = react_u;
    res.react_v     = react_v;
    res.last_result = job_r.last;
  end

endmodule

// ===== design/brusselator_stencil_residual.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brusselator_stencil_residual: 1-D Brusselator residual stage
// Streams grid points of a two-species field and returns, per point, the
// implicit residual and the hx-scaled reaction term in saturated Q16.16.
// ----------------------------------------------------------------------------
// Points enter in grid order through the push/full queue interface; the
// block keeps a three-point window and produces one result per point once
// its right-hand neighbor is in, so the first request of a sweep gives no
// result and the last-marked request gives two (a single-point sweep gives
// one). Results leave through empty/pop in order. Work is done by a back
// end with one shared 34x32 multiplier issuing one product per cycle: a
// boundary result needs 8 products and an interior result needs 12, and
// the back end works on one job at a time. The front end buffers up to four
// jobs, so short bursts are absorbed at one request per cycle while the job
// queue has room and no flush job is pending. Configuration writes take
// effect on the next clock and must only be made with the block drained.
// ----------------------------------------------------------------------------
module brusselator_stencil_residual #(
  parameter int MAX_POINTS = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  // point requests
  input  logic                            push,
  input  brs_pkg::item_t                  item,
  output logic                            full,
  // results
  output logic                            empty,
  input  logic                            pop,
  output brs_pkg::result_t                result,
  // configuration
  input  logic                            cfg_we,
  input  logic [brs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [brs_pkg::DATA_W-1:0]      cfg_data
);

  brs_pkg::cfg_t    cfg;

  // front -> job queue
  logic             fe_job_push;
  brs_pkg::job_t    fe_job;
  logic             jobq_full;
  // job queue -> back
  logic             jobq_empty;
  logic             be_job_pop;
  logic [$bits(brs_pkg::job_t)-1:0] jobq_rd;
  brs_pkg::job_t    be_job;
  // back -> result queue
  brs_pkg::result_t be_res;
  logic             be_res_push;
  logic             outq_full;
  logic [$bits(brs_pkg::result_t)-1:0] outq_rd;

  // Register file: every index of the map is a real register, values are
  // masked to each register's width on write.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= brs_pkg::CFG_RESET;
    end else if (cfg_we) begin
      unique case (brs_pkg::cfg_reg_e'(cfg_index))
        brs_pkg::REG_STEP_H:    cfg.step_h    <= cfg_data[16:0];
        brs_pkg::REG_DIFF_GAIN: cfg.diff_gain <= cfg_data[30:0];
        brs_pkg::REG_REACT_A:   cfg.react_a   <= cfg_data;
        brs_pkg::REG_REACT_B:   cfg.react_b   <= cfg_data;
        brs_pkg::REG_U_LEFT:    cfg.u_left    <= cfg_data;
        brs_pkg::REG_U_RIGHT:   cfg.u_right   <= cfg_data;
        brs_pkg::REG_V_LEFT:    cfg.v_left    <= cfg_data;
        brs_pkg::REG_V_RIGHT:   cfg.v_right   <= cfg_data;
        default:                cfg           <= cfg;
      endcase
    end
  end

  // Front end: window, point numbering, classification into jobs.
  brs_front #(
    .MAX_POINTS (MAX_POINTS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .item     (item),
    .full     (full),
    .job_full (jobq_full),
    .job_push (fe_job_push),
    .job      (fe_job)
  );

  // Decoupling queue: the front keeps taking points while the back grinds.
  brs_fifo #(
    .WIDTH ($bits(brs_pkg::job_t)),
    .DEPTH (brs_pkg::JOBQ_DEPTH)
  ) u_jobq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (fe_job_push),
    .wr_data (fe_job),
    .full    (jobq_full),
    .rd_en   (be_job_pop),
    .rd_data (jobq_rd),
    .empty   (jobq_empty)
  );

  assign be_job = brs_pkg::job_t'(jobq_rd);

  // Back end: multiplier sequencer for residual and reaction terms.
  brs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job       (be_job),
    .job_empty (jobq_empty),
    .job_pop   (be_job_pop),
    .res       (be_res),
    .res_full  (outq_full),
    .res_push  (be_res_push)
  );

  // Result queue: finished results wait here; when it is full the back end holds in BK_OUT.
  brs_fifo #(
    .WIDTH ($bits(brs_pkg::result_t)),
    .DEPTH (brs_pkg::OUTQ_DEPTH)
  ) u_outq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (be_res_push),
    .wr_data (be_res),
    .full    (outq_full),
    .rd_en   (pop),
    .rd_data (outq_rd),
    .empty   (empty)
  );

  assign result = brs_pkg::result_t'(outq_rd);

endmodule

// ===== design/brs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brs_checker: port-level checks
// Watches the top-level ports for reset behavior, result hold
// and point numbering across a sweep.
// ----------------------------------------------------------------------------
module brs_checker (
  input logic             clk,
  input logic             rst,
  input logic             full,
  input logic             empty,
  input logic             pop,
  input brs_pkg::result_t result
);

  a_reset_clear: assert property (@(posedge clk)
    rst |=> empty && !full)
    else $error("queues not clear after reset");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(result))
    else $error("waiting result changed or vanished");

  a_sweep_restart: assert property (@(posedge clk) disable iff (rst)
    !empty && pop && result.last_result |=> empty || result.point_index == 12'd0)
    else $error("new sweep does not start at index zero");

  a_index_step: assert property (@(posedge clk) disable iff (rst)
    !empty && pop && !result.last_result |=>
      empty || result.point_index == $past(result.point_index) + 12'd1 ||
      result.point_index == 12'd0)
    else $error("point index skipped within a sweep");

endmodule

bind brusselator_stencil_residual brs_checker u_brs_checker (
  .clk    (clk),
  .rst    (rst),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: regression bench for brusselator_stencil_residual
// Streams sweeps of grid points through the request queue, predicts the
// residual and reaction results per point in fixed point, and checks every
// popped result in order. Covers register settings at the extremes, random
// pacing on both sides and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
  import brs_pkg::*;

  // Run control.
  localparam int      LIMIT_CYCLES   = 2000000;
  localparam int      SETTLE_CYCLES  = 64;    // settle time at the end of each drain
  localparam int      RX_HOLD_CYCLES = 600;
  localparam int      MAX_REPORTS    = 50;
  localparam int      NUM_PHASES     = 10;
  localparam int      HOLD_PHASE     = 2;     // receiver holds off, sender keeps going
  localparam longint  Q_MAX          = 64'sd2147483647;
  localparam longint  Q_MIN          = -64'sd2147483648;

  typedef enum {CFG_TYPICAL, CFG_HIGH, CFG_LOW, CFG_RANDOM, CFG_DEFAULT} setting_e;
  typedef enum logic [1:0] {RX_STEADY, RX_HALF, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  setting_e setting_plan [NUM_PHASES] = '{CFG_TYPICAL, CFG_HIGH, CFG_TYPICAL, CFG_LOW,
                                          CFG_RANDOM, CFG_DEFAULT, CFG_RANDOM, CFG_HIGH,
                                          CFG_LOW, CFG_RANDOM};

  // DUT connections; the inputs are known from time zero.
  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 push      = 1'b0;
  item_t                req_item  = '0;
  logic                 full;
  logic                 empty;
  logic                 pop       = 1'b0;
  result_t              out_res;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]    cfg_data  = '0;

  // Stimulus and expectations.
  item_t   grid_points_q [$];    // requests waiting for the driver
  result_t stencil_out_q [$];    // predicted results, oldest first
  result_t want_res;
  int      n_errors    = 0;
  int      cycle_count = 0;
  logic    req_taken   = 1'b0;   // request accepted at the last rising edge

  // Sender pacing, set per phase.
  int tx_burst_max = 1;
  int tx_gap_max   = 0;
  int tx_burst     = 0;
  int tx_gap       = 0;

  // Receiver pattern and hold-off bookkeeping.
  int       rx_hold_reqs = 0;
  int       rx_hold_seen = 0;
  int       rx_hold_left = 0;
  int       rx_mode_left = 0;
  rx_mode_e rx_mode      = RX_STEADY;
  logic [2:0] rx_tick    = '0;

  // Predictor copy of registers and window.
  cfg_t           model_cfg = CFG_RESET;
  fill_e          win_state = FILL_EMPTY;
  longint         win_left_u = 0, win_left_v = 0;
  longint         win_mid_u = 0, win_mid_v = 0;
  longint         win_rate_u = 0, win_rate_v = 0;
  logic [11:0]    model_idx = '0;

  brusselator_stencil_residual dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .item      (req_item),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .result    (out_res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Fixed-point predictor
  // --------------------------------------------------------------------------

  // Q32 -> Q16 round to nearest, ties up; >>> on longint is a floor.
  function automatic longint q_round(longint x);
    return (x + 64'sd32768) >>> 16;
  endfunction

  function automatic longint clamp(longint x);
    if (x > Q_MAX) return Q_MAX;
    if (x < Q_MIN) return Q_MIN;
    return x;
  endfunction

  // Dirichlet term hx*(x - bnd), one rounding.
  function automatic longint boundary_res(longint x, longint bnd);
    return clamp(q_round(longint'(model_cfg.step_h) * (x - bnd)));
  endfunction

  // hx*rate - gain*(l - 2c + r) with a single rounding. The second difference
  // times the gain can pass 64 bits, so its high part is kept out of the sum
  // that gets rounded: it is already a whole multiple of one LSB.
  function automatic longint interior_res(longint l, longint c, longint r, longint rate);
    longint g, d, hi, lo;
    g  = longint'(model_cfg.diff_gain);
    d  = l - 2 * c + r;
    hi = d >>> 16;
    lo = d & 64'hFFFF;
    return clamp(((longint'(model_cfg.step_h) * rate - lo * g + 64'sd32768) >>> 16) - hi * g);
  endfunction

  // Builds one result: reaction terms come from the point's own u and v.
  function automatic result_t make_result(logic [11:0] idx, longint su, longint sv,
                                          longint u, longint v, logic fin);
    longint  h, a, b, u2, uuv, ru, rv;
    result_t r;
    h   = longint'(model_cfg.step_h);
    a   = longint'($signed(model_cfg.react_a));
    b   = longint'($signed(model_cfg.react_b));
    u2  = clamp(q_round(u * u));
    uuv = clamp(q_round(u2 * v));
    ru  = clamp(q_round(h * (a + uuv - clamp(q_round((b + 65536) * u)))));
    rv  = clamp(q_round(h * (clamp(q_round(b * u)) - uuv)));
    r.point_index = idx;
    r.resid_u     = su[31:0];
    r.resid_v     = sv[31:0];
    r.react_u     = ru[31:0];
    r.react_v     = rv[31:0];
    r.last_result = fin;
    return r;
  endfunction

  // Advances the window by one accepted request and queues what it releases.
  function automatic void stencil_predict(item_t p);
    longint pu, pv;
    pu = longint'($signed(p.point_u));
    pv = longint'($signed(p.point_v));
    if (win_state == FILL_EMPTY) begin
      if (p.last_point) begin
        // single-point sweep: left boundary only, flagged last
        stencil_out_q.push_back(make_result(12'd0,
          boundary_res(pu, longint'($signed(model_cfg.u_left))),
          boundary_res(pv, longint'($signed(model_cfg.v_left))), pu, pv, 1'b1));
      end else begin
        win_mid_u  = pu;
        win_mid_v  = pv;
        win_rate_u = longint'($signed(p.rate_u));
        win_rate_v = longint'($signed(p.rate_v));
        win_state  = FILL_FIRST;
      end
      model_idx = 12'd0;
      return;
    end
    // center point is released now that its right neighbor is here
    if (win_state == FILL_FIRST) begin
      stencil_out_q.push_back(make_result(model_idx,
        boundary_res(win_mid_u, longint'($signed(model_cfg.u_left))),
        boundary_res(win_mid_v, longint'($signed(model_cfg.v_left))),
        win_mid_u, win_mid_v, 1'b0));
    end else begin
      stencil_out_q.push_back(make_result(model_idx,
        interior_res(win_left_u, win_mid_u, pu, win_rate_u),
        interior_res(win_left_v, win_mid_v, pv, win_rate_v),
        win_mid_u, win_mid_v, 1'b0));
    end
    model_idx = model_idx + 12'd1;   // wraps at 4096
    if (p.last_point) begin
      // last point flushes itself against the right boundary
      stencil_out_q.push_back(make_result(model_idx,
        boundary_res(pu, longint'($signed(model_cfg.u_right))),
        boundary_res(pv, longint'($signed(model_cfg.v_right))), pu, pv, 1'b1));
      win_state = FILL_EMPTY;
      model_idx = 12'd0;
    end else begin
      win_left_u = win_mid_u;
      win_left_v = win_mid_v;
      win_mid_u  = pu;
      win_mid_v  = pv;
      win_rate_u = longint'($signed(p.rate_u));
      win_rate_v = longint'($signed(p.rate_v));
      win_state  = FILL_FULL;
    end
  endfunction

  function automatic int field_mismatch(string fname, logic [31:0] want, logic [31:0] got);
    if (got === want) return 0;
    if (n_errors < MAX_REPORTS)
      $display("%0t: %s mismatch: expected %h, got %h", $time, fname, want, got);
    return 1;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: one request per cycle at most, held until taken.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (!push || req_taken) begin
      if (tx_gap > 0) begin
        push   <= 1'b0;
        tx_gap <= tx_gap - 1;
      end else if (grid_points_q.size() > 0) begin
        push     <= 1'b1;
        req_item <= grid_points_q.pop_front();
        // end of a burst: draw the next gap and burst length
        if (tx_burst <= 1) begin
          tx_burst <= $urandom_range(1, tx_burst_max);
          tx_gap   <= $urandom_range(0, tx_gap_max);
        end else begin
          tx_burst <= tx_burst - 1;
        end
      end else begin
        push <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random pop pattern, plus long hold-offs on request.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (rx_hold_left > 0) begin
      pop          <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else if (rx_hold_seen != rx_hold_reqs) begin
      pop          <= 1'b0;
      rx_hold_seen <= rx_hold_reqs;
      rx_hold_left <= RX_HOLD_CYCLES;
    end else begin
      rx_tick <= rx_tick + 3'd1;
      if (rx_mode_left == 0) begin
        rx_mode      <= rx_mode_e'($urandom_range(0, 3));
        rx_mode_left <= $urandom_range(16, 400);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        RX_STEADY: pop <= 1'b1;
        RX_HALF:   pop <= ($urandom_range(0, 1) == 1);
        RX_SPARSE: pop <= ($urandom_range(0, 3) == 0);
        default:   pop <= (rx_tick < 3'd5);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check the popped result first, then predict from the request
  // taken at the same edge (it cannot affect this edge's result).
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= push && !full;
      if (pop && !empty) begin
        if (stencil_out_q.size() == 0) begin
          if (n_errors < MAX_REPORTS)
            $display("%0t: result with none expected, got %h", $time, out_res);
          n_errors++;
        end else begin
          want_res = stencil_out_q.pop_front();
          n_errors += field_mismatch("point_index", 32'(want_res.point_index),
                                     32'(out_res.point_index));
          n_errors += field_mismatch("resid_u", want_res.resid_u, out_res.resid_u);
          n_errors += field_mismatch("resid_v", want_res.resid_v, out_res.resid_v);
          n_errors += field_mismatch("react_u", want_res.react_u, out_res.react_u);
          n_errors += field_mismatch("react_v", want_res.react_v, out_res.react_v);
          n_errors += field_mismatch("last_result", 32'(want_res.last_result),
                                     32'(out_res.last_result));
        end
      end
      if (push && !full)
        stencil_predict(req_item);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("brusselator_stencil_residual regression: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic void add_point(logic [31:0] u, logic [31:0] v, logic [31:0] ru,
                                    logic [31:0] rv, logic fin);
    item_t p;
    p.point_u    = u;
    p.point_v    = v;
    p.rate_u     = ru;
    p.rate_v     = rv;
    p.last_point = fin;
    grid_points_q.push_back(p);
  endfunction

  // Mostly values of physical size, some large, some full range and corners.
  function automatic logic [31:0] grid_value();
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6, 7, 8, 9: return $urandom_range(0, 32'h80000) - 32'h40000;
      10, 11, 12, 13:               return $urandom_range(0, 32'h2000000) - 32'h1000000;
      14, 15, 16:                   return $urandom;
      17:                           return 32'h7FFFFFFF;
      18:                           return 32'h80000000;
      default: begin
        case ($urandom_range(0, 3))
          0:       return 32'h0;
          1:       return 32'h1;
          2:       return 32'hFFFFFFFF;
          default: return 32'h10000;
        endcase
      end
    endcase
  endfunction

  // Sweeps with random content; a last mark added or dropped now and then,
  // and the phase may stop mid-sweep so the next settings land inside it.
  function automatic void queue_sweeps(int n_points, int long_len);
    int   left, len;
    logic closed;
    left = n_points;
    while (left > 0) begin
      case ($urandom_range(0, 19))
        0:       len = 1;
        1, 2, 3: len = $urandom_range(9, long_len);
        default: len = $urandom_range(2, 8);
      endcase
      closed = (len <= left) || ($urandom_range(0, 1) == 1);
      if (len > left) len = left;
      for (int k = 0; k < len; k++)
        add_point(grid_value(), grid_value(), grid_value(), grid_value(),
                  ((k == len - 1) && closed) ^ ($urandom_range(0, 31) == 0));
      left -= len;
    end
  endfunction

  task automatic pick_pacing();
    case ($urandom_range(0, 2))
      0:       begin tx_burst_max = 8;  tx_gap_max = 6;  end
      1:       begin tx_burst_max = 40; tx_gap_max = 30; end
      default: begin tx_burst_max = 1;  tx_gap_max = 0;  end
    endcase
  endtask

  // Wait until every request is in and every result is out, then let the
  // back end settle (a first point of a sweep leaves no result behind).
  // Checked at the rising edge, where push and the request queue are stable.
  task automatic drain();
    while (grid_points_q.size() != 0 || push || stencil_out_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_e r, logic [31:0] d);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_data  <= d;
    case (r)
      REG_STEP_H:    model_cfg.step_h    = d[16:0];
      REG_DIFF_GAIN: model_cfg.diff_gain = d[30:0];
      REG_REACT_A:   model_cfg.react_a   = d;
      REG_REACT_B:   model_cfg.react_b   = d;
      REG_U_LEFT:    model_cfg.u_left    = d;
      REG_U_RIGHT:   model_cfg.u_right   = d;
      REG_V_LEFT:    model_cfg.v_left    = d;
      default:       model_cfg.v_right   = d;
    endcase
  endtask

  // Writes all eight registers; spare upper data bits are randomized.
  task automatic load_setting(setting_e kind);
    cfg_t s;
    case (kind)
      CFG_TYPICAL: begin
        s.step_h    = 17'($urandom_range(1, 16384));
        s.diff_gain = 31'($urandom_range(0, 32'h100000));
        s.react_a   = $urandom_range(0, 32'h100000) - 32'h80000;
        s.react_b   = $urandom_range(0, 32'h100000) - 32'h80000;
        s.u_left    = $urandom_range(0, 32'h100000) - 32'h80000;
        s.u_right   = $urandom_range(0, 32'h100000) - 32'h80000;
        s.v_left    = $urandom_range(0, 32'h100000) - 32'h80000;
        s.v_right   = $urandom_range(0, 32'h100000) - 32'h80000;
      end
      CFG_HIGH: begin
        s.step_h    = 17'd65536;
        s.diff_gain = 31'h7FFFFFFF;
        s.react_a   = 32'h7FFFFFFF;
        s.react_b   = 32'h80000000;
        s.u_left    = 32'h7FFFFFFF;
        s.u_right   = 32'h80000000;
        s.v_left    = 32'h80000000;
        s.v_right   = 32'h7FFFFFFF;
      end
      CFG_LOW: begin
        s.step_h    = 17'd0;
        s.diff_gain = 31'd0;
        s.react_a   = 32'h80000000;
        s.react_b   = 32'h7FFFFFFF;
        s.u_left    = 32'h0;
        s.u_right   = 32'h0;
        s.v_left    = 32'h0;
        s.v_right   = 32'h0;
      end
      CFG_RANDOM: begin
        s.step_h    = 17'($urandom_range(0, 65536));
        s.diff_gain = 31'($urandom);
        s.react_a   = $urandom;
        s.react_b   = $urandom;
        s.u_left    = $urandom;
        s.u_right   = $urandom;
        s.v_left    = $urandom;
        s.v_right   = $urandom;
      end
      default: s = CFG_RESET;
    endcase
    write_reg(REG_STEP_H,    {15'($urandom), s.step_h});
    write_reg(REG_DIFF_GAIN, {1'($urandom), s.diff_gain});
    write_reg(REG_REACT_A,   s.react_a);
    write_reg(REG_REACT_B,   s.react_b);
    write_reg(REG_U_LEFT,    s.u_left);
    write_reg(REG_U_RIGHT,   s.u_right);
    write_reg(REG_V_LEFT,    s.v_left);
    write_reg(REG_V_RIGHT,   s.v_right);
    @(negedge clk) cfg_we <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    @(posedge clk);

    // Directed part, reset register values.
    pick_pacing();
    // single-point sweeps at the corners of u and v
    add_point(32'h0, 32'h0, 32'h0, 32'h0, 1'b1);
    add_point(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 1'b1);
    add_point(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 1'b1);
    // two points: both ends are boundaries, no interior
    add_point(32'h10000, 32'h30000, 32'h100, 32'hFFFFFF00, 1'b0);
    add_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h0, 32'h0, 1'b1);
    // interior points with extreme neighbors and rates
    add_point(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 1'b0);
    add_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 1'b0);
    add_point(32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
    add_point(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0);
    add_point(32'hFFFFFFFF, 32'h1, 32'hFFFFFFFF, 32'hFFFF0000, 1'b1);
    // near-equilibrium sweep (u ~ 1.0, v ~ 3.0), non-saturating arithmetic
    for (int k = 0; k < 6; k++)
      add_point(32'h10000 + 32'(k * 4096), 32'h30000 - 32'(k * 8192),
                32'(k * 1000) - 32'd2500, 32'd1200 - 32'(k * 700), k == 5);
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      load_setting(setting_plan[ph]);
      @(posedge clk);
      if (ph == HOLD_PHASE) begin
        // sender offers back to back while the receiver stops popping,
        // so the block backs up and has to hold full
        tx_burst_max = 1;
        tx_gap_max   = 0;
        queue_sweeps(150, 60);
        rx_hold_reqs++;
      end else begin
        pick_pacing();
        queue_sweeps(100, 40);
      end
      drain();
    end

    @(negedge clk);
    if (n_errors == 0)
      $display("brusselator_stencil_residual regression: pass");
    else
      $display("brusselator_stencil_residual regression: fail");
    $finish;
  end

endmodule

// ===== files.f =====
design/brs_pkg.sv
design/brs_fifo.sv
design/brs_front.sv
design/brs_back.sv
design/brusselator_stencil_residual.sv
design/brs_checker.sv
verif/tb.sv
